>>> hw/rtl/aes_key_schedule_round_key_add_assert.svh
// ----------------------------------------------------------------------------
// AES key schedule / AddRoundKey assertion macros
// Concurrent checks clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef AES_KEY_SCHEDULE_ROUND_KEY_ADD_ASSERT_SVH
`define AES_KEY_SCHEDULE_ROUND_KEY_ADD_ASSERT_SVH

// same-cycle implication
`define AKS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AKS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/aesks_pkg.sv
// ----------------------------------------------------------------------------
// aesks_pkg
// Shared types, constants and the S-box for the AES key schedule block.
// ----------------------------------------------------------------------------
package aesks_pkg;

    localparam int MIN_KEY_WORDS = 4;
    localparam int MAX_KEY_WORDS = 8;
    localparam int KW_EXTRA_SUB  = 6;
    localparam int KW_EXTRA_POS  = 4;
    localparam int MIN_ROUNDS    = 10;
    localparam int ROW_WORDS     = 4;
    localparam int CFG_COUNT     = 6;

    localparam logic [7:0] RCON_INIT = 8'h8d;
    localparam logic [7:0] RCON_POLY = 8'h1b;

    typedef enum logic [2:0] {
        CFG_KEY_0_7   = 3'd0,
        CFG_KEY_8_15  = 3'd1,
        CFG_KEY_16_23 = 3'd2,
        CFG_KEY_24_31 = 3'd3,
        CFG_KEY_WORDS = 3'd4,
        CFG_ROUNDS    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic cfg_wr;
        logic load_item;
        logic exp_start;
        logic exp_step;
        logic rd_en;
        logic rd_sel_input;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic exp_last;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? RCON_POLY : 8'h00);
    endfunction

endpackage

>>> hw/rtl/aesks_ctrl.sv
// ----------------------------------------------------------------------------
// aesks_ctrl
// Sequencer: accepts words, runs the key expansion when needed, issues the
// round-key read and loads the output register.
// ----------------------------------------------------------------------------
module aesks_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  aesks_pkg::status_t status,
    output aesks_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXPAND = 4'b0010,
        ST_READ   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   keys_ready_reg, keys_ready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        cmd             = '0;
        cmd.cfg_wr      = cfg_valid;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    if (keys_ready_reg)
                    begin
                        cmd.rd_en        = 1'b1;
                        cmd.rd_sel_input = 1'b1;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        cmd.exp_start = 1'b1;
                        state_next    = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                cmd.exp_step = 1'b1;
                if (status.exp_last)
                begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && (cfg_index < 3'(aesks_pkg::CFG_COUNT)))
        begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

endmodule

>>> hw/rtl/aesks_dpath.sv
// ----------------------------------------------------------------------------
// aesks_dpath
// Key registers, one-word-per-cycle key expansion, round-key store and the
// AddRoundKey output register.
// ----------------------------------------------------------------------------
module aesks_dpath #(
    parameter int ROUND_KEY_BYTES = 240
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  aesks_pkg::cmd_t    cmd,
    output aesks_pkg::status_t status,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic [3:0]         round_index,
    input  logic [63:0]        block_high,
    input  logic [63:0]        block_low,
    output logic [63:0]        result_high,
    output logic [63:0]        result_low,
    output logic               round_error
);

    localparam int STORE_WORDS = ROUND_KEY_BYTES / 4;
    localparam int MAX_ROUNDS  = ROUND_KEY_BYTES / 16 - 1;
    localparam int DEPTH       = MAX_ROUNDS + 1;
    localparam int ROW_W       = $clog2(DEPTH);
    localparam int WORD_W      = $clog2(STORE_WORDS);
    localparam int WIN_W       = $clog2(aesks_pkg::MAX_KEY_WORDS);

    logic [63:0] key_reg [4];
    logic [3:0]  kw_reg;
    logic [3:0]  rc_reg;

    logic [3:0]  round_reg;
    logic [63:0] blk_hi_reg;
    logic [63:0] blk_lo_reg;

    logic [WORD_W-1:0] idx_reg, idx_next;
    logic [WIN_W-1:0]  pos_reg, pos_next;
    logic [7:0]        rcon_reg, rcon_next;
    logic [31:0]       win_reg [aesks_pkg::MAX_KEY_WORDS];

    logic [aesks_pkg::ROW_WORDS-1:0][31:0] store_mem [DEPTH];
    logic [aesks_pkg::ROW_WORDS-1:0][31:0] rkey_reg;

    logic [63:0] res_hi_reg;
    logic [63:0] res_lo_reg;
    logic        err_reg;

    logic [3:0]       eff_nk;
    logic [3:0]       eff_rounds;
    logic [WIN_W-1:0] nk_m1;
    logic [31:0]      tmp_word;
    logic [31:0]      key_word;
    logic [31:0]      exp_word;
    logic [63:0]      key_pair;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] rd_row;
    logic             item_err;

    always_comb
    begin
        if (kw_reg < 4'(aesks_pkg::MIN_KEY_WORDS))
            eff_nk = 4'(aesks_pkg::MIN_KEY_WORDS);
        else if (kw_reg > 4'(aesks_pkg::MAX_KEY_WORDS))
            eff_nk = 4'(aesks_pkg::MAX_KEY_WORDS);
        else
            eff_nk = kw_reg;

        if (rc_reg < 4'(aesks_pkg::MIN_ROUNDS))
            eff_rounds = 4'(aesks_pkg::MIN_ROUNDS);
        else if (rc_reg > 4'(MAX_ROUNDS))
            eff_rounds = 4'(MAX_ROUNDS);
        else
            eff_rounds = rc_reg;
    end

    assign nk_m1  = WIN_W'(eff_nk - 4'd1);
    assign wr_row = ROW_W'(idx_reg >> 2);
    assign rd_row = cmd.rd_sel_input ? ROW_W'(round_index) : ROW_W'(round_reg);

    assign status.exp_last = (idx_reg[1:0] == 2'd3) && (wr_row == ROW_W'(eff_rounds));

    // next expanded word
    always_comb
    begin
        key_pair = key_reg[idx_reg[2:1]];
        key_word = idx_reg[0] ? key_pair[31:0] : key_pair[63:32];
        tmp_word = win_reg[0];
        if (pos_reg == '0)
        begin
            tmp_word = aesks_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                       ^ {rcon_reg, 24'h000000};
        end
        else if ((eff_nk > 4'(aesks_pkg::KW_EXTRA_SUB))
                 && (pos_reg == WIN_W'(aesks_pkg::KW_EXTRA_POS)))
        begin
            tmp_word = aesks_pkg::sub_word(win_reg[0]);
        end

        if (idx_reg < WORD_W'(eff_nk))
            exp_word = key_word;
        else
            exp_word = win_reg[nk_m1] ^ tmp_word;
    end

    always_comb
    begin
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        rcon_next = rcon_reg;
        if (cmd.exp_start)
        begin
            idx_next  = '0;
            pos_next  = '0;
            rcon_next = aesks_pkg::RCON_INIT;
        end
        else if (cmd.exp_step)
        begin
            idx_next = idx_reg + WORD_W'(1);
            if (pos_reg == nk_m1)
            begin
                pos_next  = '0;
                rcon_next = aesks_pkg::xtime(rcon_reg);
            end
            else
            begin
                pos_next = pos_reg + WIN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= '0;
            key_reg[1] <= '0;
            key_reg[2] <= '0;
            key_reg[3] <= '0;
            kw_reg     <= 4'(aesks_pkg::MIN_KEY_WORDS);
            rc_reg     <= 4'(aesks_pkg::MIN_ROUNDS);
        end
        else if (cmd.cfg_wr)
        begin
            case (aesks_pkg::cfg_idx_t'(cfg_index))
                aesks_pkg::CFG_KEY_0_7:   key_reg[0] <= cfg_data;
                aesks_pkg::CFG_KEY_8_15:  key_reg[1] <= cfg_data;
                aesks_pkg::CFG_KEY_16_23: key_reg[2] <= cfg_data;
                aesks_pkg::CFG_KEY_24_31: key_reg[3] <= cfg_data;
                aesks_pkg::CFG_KEY_WORDS: kw_reg     <= cfg_data[3:0];
                aesks_pkg::CFG_ROUNDS:    rc_reg     <= cfg_data[3:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        rcon_reg <= rcon_next;
        if (cmd.exp_step)
        begin
            win_reg[0] <= exp_word;
            for (int k = 1; k < aesks_pkg::MAX_KEY_WORDS; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
        if (cmd.load_item)
        begin
            round_reg  <= round_index;
            blk_hi_reg <= block_high;
            blk_lo_reg <= block_low;
        end
    end

    // round-key store: one word written, one row read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.exp_step)
        begin
            store_mem[wr_row][idx_reg[1:0]] <= exp_word;
        end
        if (cmd.rd_en)
        begin
            rkey_reg <= store_mem[rd_row];
        end
    end

    assign item_err = (round_reg > eff_rounds);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            err_reg <= item_err;
            if (item_err)
            begin
                res_hi_reg <= blk_hi_reg;
                res_lo_reg <= blk_lo_reg;
            end
            else
            begin
                res_hi_reg <= blk_hi_reg ^ {rkey_reg[0], rkey_reg[1]};
                res_lo_reg <= blk_lo_reg ^ {rkey_reg[2], rkey_reg[3]};
            end
        end
    end

    assign result_high = res_hi_reg;
    assign result_low  = res_lo_reg;
    assign round_error = err_reg;

endmodule

>>> hw/rtl/aes_key_schedule_round_key_add.sv
// ----------------------------------------------------------------------------
// aes_key_schedule_round_key_add
// AES-128/192/256 key expansion into a round-key store, then AddRoundKey on
// each incoming 16-byte block for the round it names.
// ----------------------------------------------------------------------------
// With the round keys in place a word is accepted and its round-key row is
// read from the store; the word is then XORed and loaded into the output
// register once that register is free. The first word after reset or after a
// write to one of the six configuration registers first expands the key, one
// 32-bit word per cycle, into 4*(R+1) words, R being the effective round count (10 to 14). The output register
// lets the next word be taken while a result waits for m_tready.
module aes_key_schedule_round_key_add #(
    parameter int ROUND_KEY_BYTES = 240
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // round_index[3:0], block_high[67:4], block_low[131:68]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // result_high[63:0], result_low[127:64]
    output logic         m_tuser,   // round_error[0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    aesks_pkg::cmd_t    cmd;
    aesks_pkg::status_t status;
    logic [63:0]        result_high;
    logic [63:0]        result_low;
    logic               round_error;

    aesks_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    aesks_dpath #(
        .ROUND_KEY_BYTES (ROUND_KEY_BYTES)
    ) u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .round_index (s_tdata[3:0]),
        .block_high  (s_tdata[67:4]),
        .block_low   (s_tdata[131:68]),
        .result_high (result_high),
        .result_low  (result_low),
        .round_error (round_error)
    );

    assign m_tdata = {result_low, result_high};
    assign m_tuser = round_error;

`include "aes_key_schedule_round_key_add_assert.svh"

    `AKS_ASSERT_NEXT(a_accept_blocks, s_tvalid && s_tready, !s_tready, "second word taken before first finished")
    `AKS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "output register overwritten")
    `AKS_ASSERT_SAME(a_expand_busy, cmd.exp_step, !s_tready, "expansion step while accepting")
    `AKS_ASSERT_NEXT(a_expand_ends, cmd.exp_step && status.exp_last, !cmd.exp_step, "expansion ran past last word")

endmodule

>>> sim/aes_key_schedule_round_key_add_tb.sv
// ----------------------------------------------------------------------------
// aes_key_schedule_round_key_add_tb
// Drives blocks and key settings into the key schedule / AddRoundKey block,
// and checks every result word against a predictor that expands the key
// itself. The run covers the standard key sizes and saturated settings,
// then random phases with random stalls on both streams.
// ----------------------------------------------------------------------------
module aes_key_schedule_round_key_add_tb;

    localparam int RK_BYTES    = 240;
    localparam int STORE_WORDS = RK_BYTES / 4;
    localparam int MAX_ROUND   = RK_BYTES / 16 - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1000;
    localparam int CALM_FROM   = 850;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        round_error;
    } ark_result_t;

    class ark_scoreboard;
        logic [63:0] key_reg [4];
        logic [3:0]  key_words_reg;
        logic [3:0]  rounds_reg;
        logic [31:0] key_store [STORE_WORDS];
        bit          keys_ready;
        ark_result_t expected_blocks [$];
        int          mismatches;

        function new();
            foreach (key_reg[i]) key_reg[i] = '0;
            foreach (key_store[i]) key_store[i] = '0;
            key_words_reg = 4'(aesks_pkg::MIN_KEY_WORDS);
            rounds_reg    = 4'(aesks_pkg::MIN_ROUNDS);
            keys_ready    = 1'b0;
            mismatches    = 0;
        endfunction

        function int key_word_count();
            if (key_words_reg < aesks_pkg::MIN_KEY_WORDS) return aesks_pkg::MIN_KEY_WORDS;
            if (key_words_reg > aesks_pkg::MAX_KEY_WORDS) return aesks_pkg::MAX_KEY_WORDS;
            return key_words_reg;
        endfunction

        function int round_limit();
            if (rounds_reg < aesks_pkg::MIN_ROUNDS) return aesks_pkg::MIN_ROUNDS;
            if (rounds_reg > MAX_ROUND) return MAX_ROUND;
            return rounds_reg;
        endfunction

        function logic [31:0] substitute(logic [31:0] w);
            logic [31:0] s;
            for (int b = 0; b < 4; b++) s[8*b +: 8] = aesks_pkg::SBOX[w[8*b +: 8]];
            return s;
        endfunction

        function void expand_keys();
            int          nk;
            int          total;
            logic [31:0] t;
            logic [63:0] r;
            logic [7:0]  rc;
            nk    = key_word_count();
            total = aesks_pkg::ROW_WORDS * (round_limit() + 1);
            if (total > STORE_WORDS) total = STORE_WORDS;
            rc = aesks_pkg::RCON_INIT;
            for (int i = 0; i < total; i++) begin
                if (i < nk) begin
                    r = key_reg[(i >> 1) & 3];
                    key_store[i] = (i & 1) ? r[31:0] : r[63:32];
                end else begin
                    t = key_store[i - 1];
                    if (i % nk == 0) begin
                        rc = {rc[6:0], 1'b0} ^ (rc[7] ? aesks_pkg::RCON_POLY : 8'h00);
                        t  = substitute({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                    end else if (nk > aesks_pkg::KW_EXTRA_SUB
                                 && i % nk == aesks_pkg::KW_EXTRA_POS) begin
                        t = substitute(t);
                    end
                    key_store[i] = key_store[i - nk] ^ t;
                end
            end
            keys_ready = 1'b1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                aesks_pkg::CFG_KEY_0_7, aesks_pkg::CFG_KEY_8_15,
                aesks_pkg::CFG_KEY_16_23, aesks_pkg::CFG_KEY_24_31:
                    key_reg[idx[1:0]] = value;
                aesks_pkg::CFG_KEY_WORDS: key_words_reg = value[3:0];
                aesks_pkg::CFG_ROUNDS:    rounds_reg    = value[3:0];
                default:                  return;
            endcase
            keys_ready = 1'b0;
        endfunction

        function void note_block(logic [3:0] round, logic [63:0] hi, logic [63:0] lo);
            ark_result_t exp;
            int          b;
            if (!keys_ready) expand_keys();
            if (round > round_limit()) begin
                exp = '{hi, lo, 1'b1};
            end else begin
                b   = round * aesks_pkg::ROW_WORDS;
                exp = '{hi ^ {key_store[b], key_store[b + 1]},
                        lo ^ {key_store[b + 2], key_store[b + 3]}, 1'b0};
            end
            expected_blocks.push_back(exp);
        endfunction

        function void check_block(logic [63:0] hi, logic [63:0] lo, logic err);
            ark_result_t exp;
            if (expected_blocks.size() == 0) begin
                $error("unexpected result word high %h low %h error %b", hi, lo, err);
                mismatches++;
                return;
            end
            exp = expected_blocks.pop_front();
            if (hi !== exp.result_high) begin
                $error("result_high expected %h actual %h", exp.result_high, hi);
                mismatches++;
            end
            if (lo !== exp.result_low) begin
                $error("result_low expected %h actual %h", exp.result_low, lo);
                mismatches++;
            end
            if (err !== exp.round_error) begin
                $error("round_error expected %b actual %b", exp.round_error, err);
                mismatches++;
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    ark_scoreboard board = new();
    bit            idle_on = 1'b1;
    int            ready_hold = 0;
    int            cycle_count = 0;
    int            sent = 0;

    aes_key_schedule_round_key_add #(
        .ROUND_KEY_BYTES(RK_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            m_tready = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 6) == 0)
        begin
            m_tready = 1'b0;
            ready_hold = $urandom_range(1, 16) - 1;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_block(m_tdata[63:0], m_tdata[127:64], m_tuser);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] nibble_word(logic [3:0] n);
        logic [63:0] v;
        v = rand64();
        v[3:0] = n;
        return v;
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic push_block(input logic [3:0] round, input logic [63:0] hi,
                              input logic [63:0] lo);
        s_tvalid = 1'b1;
        s_tdata  = {4'h0, lo, hi, round};
        do @(posedge clk); while (!s_tready);
        board.note_block(round, hi, lo);
        sent++;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    task automatic await_results();
        s_tvalid = 1'b0;
        while (board.expected_blocks.size() != 0) @(negedge clk);
    endtask

    task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic [3:0] nk, input logic [3:0] nr);
        cfg_write(aesks_pkg::CFG_KEY_0_7, k0);
        cfg_write(aesks_pkg::CFG_KEY_8_15, k1);
        cfg_write(aesks_pkg::CFG_KEY_16_23, k2);
        cfg_write(aesks_pkg::CFG_KEY_24_31, k3);
        cfg_write(aesks_pkg::CFG_KEY_WORDS, nibble_word(nk));
        cfg_write(aesks_pkg::CFG_ROUNDS, nibble_word(nr));
    endtask

    task automatic random_setup();
        logic [3:0] nk;
        logic [3:0] nr;
        int         profile;
        profile = $urandom_range(0, 3);
        nk = (profile < 3) ? 4'(aesks_pkg::MIN_KEY_WORDS + 2 * profile)
                           : 4'($urandom_range(0, 15));
        nr = (profile < 3) ? 4'(aesks_pkg::MIN_ROUNDS + 2 * profile)
                           : 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) cfg_write(aesks_pkg::CFG_KEY_0_7, rand64());
        if ($urandom_range(0, 1) == 0) cfg_write(aesks_pkg::CFG_KEY_8_15, rand64());
        if ($urandom_range(0, 1) == 0) cfg_write(aesks_pkg::CFG_KEY_16_23, rand64());
        if ($urandom_range(0, 1) == 0) cfg_write(aesks_pkg::CFG_KEY_24_31, rand64());
        if ($urandom_range(0, 7) == 0)
            cfg_write(3'(aesks_pkg::CFG_COUNT + $urandom_range(0, 1)), rand64());
        if ($urandom_range(0, 3) != 0) cfg_write(aesks_pkg::CFG_KEY_WORDS, nibble_word(nk));
        if ($urandom_range(0, 3) != 0) cfg_write(aesks_pkg::CFG_ROUNDS, nibble_word(nr));
    endtask

    initial
    begin
        int          phase;
        int          count;
        logic [3:0]  round;
        logic [63:0] hi;
        logic [63:0] lo;
        int          mode;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset key: all zero, AES-128 schedule
        push_block(4'd0, 64'h0, 64'h0);
        push_block(4'd10, '1, '1);
        push_block(4'd11, 64'h0123456789abcdef, 64'hfedcba9876543210);
        push_block(4'd15, '1, 64'h0);
        await_results();

        load_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0, 64'h0, 4'd4, 4'd10);
        push_block(4'd0, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        push_block(4'd10, rand64(), rand64());
        push_block(4'd11, rand64(), rand64());
        await_results();

        load_key(64'h8e73b0f7da0e6452, 64'hc810f32b809079e5, 64'h62f8ead2522c6b7b,
                 '1, 4'd6, 4'd12);
        push_block(4'd12, rand64(), rand64());
        push_block(4'd13, rand64(), rand64());
        push_block(4'd6, '1, '1);
        await_results();

        load_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781, 64'h1f352c073b6108d7,
                 64'h2d9810a30914dff4, 4'd8, 4'd14);
        push_block(4'd14, rand64(), rand64());
        push_block(4'd15, rand64(), rand64());
        push_block(4'd7, 64'h0, 64'h0);
        await_results();

        // saturate both counts at each end
        cfg_write(aesks_pkg::CFG_KEY_WORDS, nibble_word(4'd0));
        cfg_write(aesks_pkg::CFG_ROUNDS, nibble_word(4'd15));
        push_block(4'd14, rand64(), rand64());
        push_block(4'd15, rand64(), rand64());
        await_results();
        cfg_write(aesks_pkg::CFG_KEY_WORDS, nibble_word(4'd15));
        cfg_write(aesks_pkg::CFG_ROUNDS, nibble_word(4'd0));
        push_block(4'd10, rand64(), rand64());
        push_block(4'd11, rand64(), rand64());
        await_results();

        // unused indexes leave the schedule alone
        cfg_write(3'(aesks_pkg::CFG_COUNT), rand64());
        cfg_write(3'(aesks_pkg::CFG_COUNT + 1), rand64());
        push_block(4'd3, rand64(), rand64());
        await_results();

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            idle_on = (sent < CALM_FROM) && ($urandom_range(0, 4) != 0);
            if ($urandom_range(0, 5) != 0) random_setup();
            count = $urandom_range(10, 60);
            for (int n = 0; n < count; n++)
            begin
                if (phase == 1 && n == count / 2) await_results();
                if ($urandom_range(0, 4) == 0)
                    round = 4'($urandom_range(0, 15));
                else
                    round = 4'($urandom_range(0, board.round_limit()));
                mode = $urandom_range(0, 9);
                hi = (mode == 0) ? 64'h0 : (mode == 1) ? '1 : rand64();
                lo = (mode == 0) ? 64'h0 : (mode == 1) ? '1 : rand64();
                push_block(round, hi, lo);
            end
            await_results();
            phase++;
        end

        repeat (80) @(negedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
